// ===== rtl/double_ended_queue_with_delete_top_macros.svh =====
// assertion macros for the double-ended queue with delete
// used by the top level only, no other dependencies
`ifndef DOUBLE_ENDED_QUEUE_WITH_DELETE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DELETE_TOP_MACROS_SVH

`ifndef SYNTH

// check a property while out of reset
`define DEQD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deque check failed");

// check a property at every edge, reset included
`define DEQD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("deque check failed");

`else

`define DEQD_ASSERT(name, clk, rst, prop)
`define DEQD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== rtl/deqd_pkg.sv =====
// shared types for the double-ended queue with delete
// no dependencies
package deqd_pkg;

   // operation codes carried in the mode field
   typedef enum logic [2:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_POP_BACK   = 3'd1,
      MODE_PUSH_FRONT = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_DELETE     = 3'd4
   } mode_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_front;
      logic delete_match;
   } cell_cmd_type;

endpackage

// ===== rtl/deqd_if.sv =====
// request and response channel interfaces for the deque
// no dependencies
interface deqd_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [2:0]            mode;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface deqd_rsp_if #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] popped_value;
   logic                  succeeded;
   logic [CNT_W-1:0]      occupancy;

   modport source (output valid, output popped_value, output succeeded,
                   output occupancy, input ready);
   modport sink (input valid, input popped_value, input succeeded,
                 input occupancy, output ready);
endinterface

// ===== rtl/deqd_cell.sv =====
// one storage cell of the deque chain
// depends on deqd_pkg
module deqd_cell
   import deqd_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [CNT_W-1:0]      count,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  match_in,
   output logic                  match_out,
   input  logic [DATA_WIDTH-1:0] back_in,
   output logic [DATA_WIDTH-1:0] back_out,
   output logic [DATA_WIDTH-1:0] data_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  occupied;
   logic                  is_back;

   // position of this cell against the fill level
   assign occupied = CNT_W'(INDEX) < count;
   assign is_back  = CNT_W'(INDEX + 1) == count;

   // first-match ripple, front to back
   assign match_out = match_in | (occupied & (data_ff == value));

   // back word ripple, back to front
   assign back_out = is_back ? data_ff : back_in;
   assign data_out = data_ff;

   // next word: write, shift toward back, or close a gap
   always_comb begin
      data_in = data_ff;
      if (cmd.push_back && (CNT_W'(INDEX) == count)) begin
         data_in = value;
      end else if (cmd.push_front) begin
         data_in = left_data;
      end else if (cmd.pop_front) begin
         data_in = right_data;
      end else if (cmd.delete_match && match_out) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/deqd_ctrl.sv =====
// operation decode, fill count and response register of the deque
// depends on deqd_pkg
module deqd_ctrl
   import deqd_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2:0]            in_mode,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_popped_value,
   output logic                  out_succeeded,
   output logic [CNT_W-1:0]      out_occupancy,
   input  logic                  found,
   input  logic [DATA_WIDTH-1:0] front_data,
   input  logic [DATA_WIDTH-1:0] back_data,
   output cell_cmd_type          cmd,
   output logic [CNT_W-1:0]      count
);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] popped_ff;
   logic [DATA_WIDTH-1:0] popped_in;
   logic                  ok_ff;
   logic                  ok_in;
   logic [CNT_W-1:0]      occ_ff;
   logic                  fire;
   logic                  full;
   logic                  empty;

   // take a word whenever the response register is free or draining
   assign in_ready = !rsp_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign empty    = count_ff == '0;

   // decode the operation
   always_comb begin
      cmd       = '0;
      count_in  = count_ff;
      ok_in     = 1'b0;
      popped_in = '0;
      unique case (mode_type'(in_mode))
         MODE_PUSH_BACK: begin
            if (!full) begin
               cmd.push_back = fire;
               count_in      = count_ff + CNT_W'(1);
               ok_in         = 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (!empty) begin
               count_in  = count_ff - CNT_W'(1);
               ok_in     = 1'b1;
               popped_in = back_data;
            end
         end
         MODE_PUSH_FRONT: begin
            if (!full) begin
               cmd.push_front = fire;
               count_in       = count_ff + CNT_W'(1);
               ok_in          = 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (!empty) begin
               cmd.pop_front = fire;
               count_in      = count_ff - CNT_W'(1);
               ok_in         = 1'b1;
               popped_in     = front_data;
            end
         end
         MODE_DELETE: begin
            cmd.delete_match = fire;
            if (found) begin
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // fill count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            count_ff <= count_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         popped_ff <= popped_in;
         ok_ff     <= ok_in;
         occ_ff    <= count_in;
      end
   end

   assign out_valid        = rsp_valid_ff;
   assign out_popped_value = popped_ff;
   assign out_succeeded    = ok_ff;
   assign out_occupancy    = occ_ff;
   assign count            = count_ff;

endmodule

// ===== rtl/double_ended_queue_with_delete_top.sv =====
// Double-ended queue with delete: CAPACITY words of DATA_WIDTH bits held in a
// row of cells, front in cell 0. Push and pop at either end, plus delete of
// the first word from the front that equals the given value. One operation can
// be taken every cycle; its response appears in the output register in the
// next cycle, and a word is taken while a response waits only if that response
// is taken in the same cycle. A delete compares every cell in parallel and the
// first-match flag ripples along the cell row, so that compare and ripple
// over all CAPACITY cells set the clock path. No clearing pass after reset.
// depends on deqd_pkg, deqd_if, deqd_cell, deqd_ctrl and the macros header
`include "double_ended_queue_with_delete_top_macros.svh"

module double_ended_queue_with_delete_top
   import deqd_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   deqd_req_if.sink   req_if,
   deqd_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_cmd_type          cmd;
   logic [CNT_W-1:0]      count;
   logic                  found;
   logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
   logic [DATA_WIDTH-1:0] left_data  [CAPACITY];
   logic [DATA_WIDTH-1:0] right_data [CAPACITY];
   logic [DATA_WIDTH-1:0] back_chain [CAPACITY+1];
   logic [CAPACITY:0]     match_chain;

   // chain ends
   assign match_chain[0]       = 1'b0;
   assign back_chain[CAPACITY] = '0;
   assign found                = match_chain[CAPACITY];

   // control and response register
   deqd_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_if.valid),
      .in_ready         (req_if.ready),
      .in_mode          (req_if.mode),
      .out_valid        (rsp_if.valid),
      .out_ready        (rsp_if.ready),
      .out_popped_value (rsp_if.popped_value),
      .out_succeeded    (rsp_if.succeeded),
      .out_occupancy    (rsp_if.occupancy),
      .found            (found),
      .front_data       (cell_data[0]),
      .back_data        (back_chain[0]),
      .cmd              (cmd),
      .count            (count)
   );

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_front
         assign left_data[i] = req_if.value;
      end else begin : g_left
         assign left_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign right_data[i] = cell_data[i];
      end else begin : g_right
         assign right_data[i] = cell_data[i+1];
      end

      deqd_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count),
         .value      (req_if.value),
         .left_data  (left_data[i]),
         .right_data (right_data[i]),
         .match_in   (match_chain[i]),
         .match_out  (match_chain[i+1]),
         .back_in    (back_chain[i+1]),
         .back_out   (back_chain[i]),
         .data_out   (cell_data[i])
      );
   end

   // fill level stays within capacity
   `DEQD_ASSERT(a_count_range, clock, reset, count <= CNT_W'(CAPACITY))

   // a push into a queue with room reports one more word
   `DEQD_ASSERT(a_push_grows, clock, reset,
      (req_if.valid && req_if.ready && count != CNT_W'(CAPACITY) &&
       (req_if.mode == MODE_PUSH_BACK || req_if.mode == MODE_PUSH_FRONT))
      |=> (rsp_if.valid && rsp_if.occupancy == $past(count) + CNT_W'(1)))

   // a failed operation never hands back data
   `DEQD_ASSERT(a_fail_zero, clock, reset,
      (rsp_if.valid && !rsp_if.succeeded) |-> (rsp_if.popped_value == '0))

   // no response straight after reset
   `DEQD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_if.valid)

endmodule

// ===== verif/deqd_checker.sv =====
// checker for the double-ended queue with delete: watches both channels,
// keeps its own copy of the held words and compares every response word
// depends on deqd_pkg for the operation codes
module deqd_checker
   import deqd_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [2:0]            req_mode,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [DATA_WIDTH-1:0] rsp_popped_value,
   input  logic                  rsp_succeeded,
   input  logic [CNT_W-1:0]      rsp_occupancy,
   output int unsigned           fail_count,
   output int unsigned           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] popped_value;
      logic                  succeeded;
      logic [CNT_W-1:0]      occupancy;
   } deque_result_type;

   // held words, front first, and responses still owed by the block
   logic [DATA_WIDTH-1:0] held_words[$];
   deque_result_type      owed_results[$];

   // apply one operation to the held words and return its response word
   function automatic deque_result_type apply_deque_op(
      input logic [2:0]            op,
      input logic [DATA_WIDTH-1:0] word
   );
      deque_result_type res;
      int               hit;
      res = '0;
      hit = -1;
      case (op)
         MODE_PUSH_BACK: begin
            if (held_words.size() < CAPACITY) begin
               held_words.push_back(word);
               res.succeeded = 1'b1;
            end
         end
         MODE_PUSH_FRONT: begin
            if (held_words.size() < CAPACITY) begin
               held_words.push_front(word);
               res.succeeded = 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (held_words.size() > 0) begin
               res.popped_value = held_words.pop_back();
               res.succeeded    = 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (held_words.size() > 0) begin
               res.popped_value = held_words.pop_front();
               res.succeeded    = 1'b1;
            end
         end
         MODE_DELETE: begin
            // first match seen from the front
            foreach (held_words[i])
               if (hit < 0 && held_words[i] == word) hit = i;
            if (hit >= 0) begin
               held_words.delete(hit);
               res.succeeded = 1'b1;
            end
         end
         default: ;
      endcase
      res.occupancy = CNT_W'(held_words.size());
      return res;
   endfunction

   // predict on each accepted request word, compare on each accepted response word
   always @(posedge clock) begin : watch_words
      deque_result_type want;
      int unsigned      errs;
      errs = 0;
      if (reset) begin
         held_words.delete();
         owed_results.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready)
            owed_results.push_back(apply_deque_op(req_mode, req_value));
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("response word with none owed: popped_value %h succeeded %b occupancy %0d",
                      rsp_popped_value, rsp_succeeded, rsp_occupancy);
               errs++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_popped_value !== want.popped_value) begin
                  $error("popped_value mismatch: expected %h, actual %h",
                         want.popped_value, rsp_popped_value);
                  errs++;
               end
               if (rsp_succeeded !== want.succeeded) begin
                  $error("succeeded mismatch: expected %b, actual %b",
                         want.succeeded, rsp_succeeded);
                  errs++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy mismatch: expected %0d, actual %0d",
                         want.occupancy, rsp_occupancy);
                  errs++;
               end
            end
         end
         fail_count    <= fail_count + errs;
         pending_count <= owed_results.size();
      end
   end

endmodule

// ===== verif/testbench.sv =====
// top of the deque testbench: clock, reset, request and response traffic
// and the verdict; depends on deqd_pkg, deqd_if, the block and deqd_checker
module testbench
   import deqd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = 16;
   localparam int DATA_WIDTH     = 32;
   localparam int CNT_W          = 5;
   localparam int RANDOM_OPS     = 470;
   localparam int CALM_OPS       = 50;
   localparam int RX_HOLD_CYCLES = 60;
   localparam int TAIL_CYCLES    = 8;

   // first mode value outside the defined operations
   localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;

   logic                  clock;
   logic                  reset;
   bit                    idle_on;
   bit                    rx_hold_req;
   int unsigned           fail_count;
   int unsigned           pending_count;
   int unsigned           ops_sent;
   logic [DATA_WIDTH-1:0] value_pool[8];

   deqd_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
   deqd_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W)) rsp_ch ();

   double_ended_queue_with_delete_top #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   deqd_checker #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_mode         (req_ch.mode),
      .req_value        (req_ch.value),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_popped_value (rsp_ch.popped_value),
      .rsp_succeeded    (rsp_ch.succeeded),
      .rsp_occupancy    (rsp_ch.occupancy),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("double_ended_queue_with_delete_top verification failed");
      $finish;
   end

   // response side: random stalls, plus one long hold on request
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            rx_hold_req = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // offer one request word and wait for it to be taken
   task automatic send_word(input logic [2:0] op, input logic [DATA_WIDTH-1:0] word);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= op;
      req_ch.value <= word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop offering until every owed response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // random operation; push_pct sets how hard the deque is pushed towards full
   task automatic send_random_op(input int unsigned push_pct);
      int unsigned           pick;
      logic [2:0]            op;
      logic [DATA_WIDTH-1:0] word;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         op = MODE_FIRST_UNUSED + 3'($urandom_range(0, 2));
      else if (pick < push_pct)
         op = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      else if (pick < push_pct + 15)
         op = MODE_DELETE;
      else
         op = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
      // a small pool of values makes deletes hit often
      word = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
      send_word(op, word);
      if (op <= MODE_DELETE) ops_sent++;
   endtask

   // directed corners: empty, full, duplicates, unused modes
   task automatic run_directed();
      logic [DATA_WIDTH-1:0] fill_words[16] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
         32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
         32'h1234_5678, 32'hFFFF_FFFE, 32'h0001_0000, 32'hC3C3_3C3C,
         32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      // pops and delete on an empty deque
      send_word(MODE_POP_BACK, 32'hFFFF_FFFF);
      send_word(MODE_POP_FRONT, 32'h0000_0000);
      send_word(MODE_DELETE, 32'h0000_0000);
      for (int k = 0; k < 3; k++)
         send_word(MODE_FIRST_UNUSED + 3'(k), 32'hFFFF_FFFF);
      // fill from both ends
      foreach (fill_words[i])
         send_word(i % 2 ? MODE_PUSH_FRONT : MODE_PUSH_BACK, fill_words[i]);
      // push when full at both ends
      send_word(MODE_PUSH_BACK, 32'hFFFF_FFFF);
      send_word(MODE_PUSH_FRONT, 32'h0000_0000);
      // delete hits the first of two duplicates, then one with no match
      send_word(MODE_DELETE, 32'hA5A5_A5A5);
      send_word(MODE_DELETE, 32'h1357_9BDF);
      send_word(MODE_POP_FRONT, 32'h0000_0000);
      send_word(MODE_POP_BACK, 32'h0000_0000);
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int unsigned phase;
      int unsigned push_pct;
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_PUSH_BACK;
      req_ch.value <= '0;
      reset        <= 1'b1;
      idle_on      = 1'b1;
      rx_hold_req  = 1'b0;
      ops_sent     = 0;
      phase        = 0;
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      // long response hold while requests keep coming
      rx_hold_req = 1'b1;
      repeat (30) send_random_op(70);
      wait_drained();

      // phases that fill, drain and churn the deque
      while (ops_sent < RANDOM_OPS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case (phase % 3)
            0:       push_pct = 75;
            1:       push_pct = 25;
            default: push_pct = 45;
         endcase
         repeat ($urandom_range(30, 60)) send_random_op(push_pct);
         if ($urandom_range(0, 1)) wait_drained();
         phase++;
      end

      // final stretch at full rate
      idle_on = 1'b0;
      repeat (CALM_OPS) send_random_op(45);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("double_ended_queue_with_delete_top verification clean");
      else
         $display("double_ended_queue_with_delete_top verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/deqd_pkg.sv
rtl/deqd_if.sv
rtl/deqd_cell.sv
rtl/deqd_ctrl.sv
rtl/double_ended_queue_with_delete_top.sv
verif/deqd_checker.sv
verif/testbench.sv
